>>> rtl/mrve_pkg.sv
// ----------------------------------------------------------------------------
// mrve_pkg: shared types and constants of the mixed-radix vector encoder
// Word formats, queue command, back-end states and the bound arithmetic.
// ----------------------------------------------------------------------------
package mrve_pkg;

	// default sizes
	localparam int MAX_ELEMENTS_DEF  = 1024;
	localparam int MAX_BYTES_DEF     = 4096;
	localparam int ELEMENT_WIDTH_DEF = 32;

	// field widths
	localparam int VALUE_W     = 16;
	localparam int COUNT_W     = 11;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// a bound after shedding is below 2^14, so a merged bound fits in 28 bits
	localparam int SHED_W     = 14;
	localparam int BOUND_W    = 2 * SHED_W;
	localparam int SHED_LIMIT = 16384;

	// reset values of the registers
	localparam logic [VALUE_W-1:0] BOUND_RESET = 16'd4591;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd761;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_BOUND = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_COUNT = 2'd1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_DONE = 2'd1,
		ST_NO_BYTES = 2'd2
	} status_t;

	typedef struct packed {
		logic               action;
		logic [VALUE_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		status_t    status;
	} out_word_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic                   valid;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_FETCH,
		BK_RD,
		BK_GET,
		BK_SHED,
		BK_MUL,
		BK_WR,
		BK_ODD_WR,
		BK_LAYER,
		BK_ROOT_RD,
		BK_ROOT_GET,
		BK_ROOT_SHED
	} back_state_t;

	// ceil(m / 256)
	function automatic logic [BOUND_W-1:0] ceil256(input logic [BOUND_W-1:0] m);
		logic [BOUND_W-1:0] q;
		q = m >> 8;
		return q + {{(BOUND_W-1){1'b0}}, |m[7:0]};
	endfunction

endpackage

>>> rtl/mrve_front.sv
// ----------------------------------------------------------------------------
// mrve_front: input stage
// Registers each accepted word, classifies it as load or fetch and hands the
// command to the queue.
// ----------------------------------------------------------------------------
module mrve_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mrve_pkg::in_word_t in_data,
	output logic              push,
	output mrve_pkg::cmd_t    push_cmd,
	input  logic              queue_full
);

	logic           hold_q;
	mrve_pkg::cmd_t cmd_q;

	assign push     = hold_q && !queue_full;
	assign push_cmd = cmd_q;
	assign in_ready = !hold_q || !queue_full;

	// valid flag of the holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_ready) begin
			hold_q <= in_valid;
		end
	end

	// classify and hold the payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q.kind  <= in_data.action ? mrve_pkg::CMD_FETCH : mrve_pkg::CMD_LOAD;
			cmd_q.value <= in_data.value;
		end
	end

endmodule

>>> rtl/mrve_queue.sv
// ----------------------------------------------------------------------------
// mrve_queue: command queue
// Short FIFO between the front stage and the back end.
// ----------------------------------------------------------------------------
module mrve_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrve_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output mrve_pkg::cmd_t head_cmd
);

	localparam int Depth = mrve_pkg::QUEUE_DEPTH;
	localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW    = $clog2(Depth + 1);

	mrve_pkg::cmd_t slot_q [Depth];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CW-1:0]  cnt_q;

	assign full       = (cnt_q == CW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = slot_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/mrve_back.sv
// ----------------------------------------------------------------------------
// mrve_back: execution back end
// Holds the element and byte memories, runs the layered encoding and answers
// fetches through the output register.
// ----------------------------------------------------------------------------
module mrve_back #(
	parameter int MAX_ELEMENTS  = mrve_pkg::MAX_ELEMENTS_DEF,
	parameter int MAX_BYTES     = mrve_pkg::MAX_BYTES_DEF,
	parameter int ELEMENT_WIDTH = mrve_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  mrve_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	input  mrve_pkg::cfg_wr_t  cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output mrve_pkg::out_word_t out_data
);

	localparam int EW   = ELEMENT_WIDTH;
	localparam int NW   = $clog2(MAX_ELEMENTS + 1);
	localparam int EAW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int BCW  = $clog2(MAX_BYTES + 1);
	localparam int BAW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CMPW = (NW > mrve_pkg::COUNT_W) ? NW : mrve_pkg::COUNT_W;
	localparam int BW   = mrve_pkg::BOUND_W;
	localparam int SW   = mrve_pkg::SHED_W;

	// registers
	logic [mrve_pkg::VALUE_W-1:0] bound_q;
	logic [mrve_pkg::COUNT_W-1:0] count_q;

	// control
	mrve_pkg::back_state_t state_q, state_d;
	logic [NW-1:0]  li_q;
	logic [BCW-1:0] bcnt_q;
	logic [BCW-1:0] rd_q;
	logic           done_q;
	logic [NW-1:0]  n_q;
	logic [NW-1:0]  i_q;
	logic [NW-1:0]  j_q;
	logic           half_q;

	// datapath
	logic [EW-1:0] cur_q;
	logic [BW-1:0] m_q;
	logic [EW-1:0] lo_q;
	logic [SW-1:0] lom_q;
	logic [EW-1:0] prod_q;
	logic [SW-1:0] bcs_q;
	logic [SW-1:0] bls_q;
	logic [BW-1:0] bc_q;
	logic [BW-1:0] bl_q;
	mrve_pkg::status_t fst_q;
	logic          flast_q;

	// memories
	logic [EW-1:0] elem_mem [MAX_ELEMENTS];
	logic [EW-1:0] elem_rd_q;
	logic [7:0]    byte_mem [MAX_BYTES];
	logic [7:0]    byte_rd_q;

	// derived values
	logic [CMPW-1:0]   n_act;
	logic [NW-1:0]     load_idx;
	logic [NW-1:0]     li_next;
	logic              start_enc;
	logic              out_free;
	logic              at_last;
	logic              shed_go;
	logic              root_go;
	logic [EW+SW-1:0]  mul_full;

	logic              elem_we;
	logic [EAW-1:0]    elem_wa;
	logic [EW-1:0]     elem_wd;
	logic              emit;
	logic              byte_we;

	// active element count, clamped to 1..MAX_ELEMENTS
	always_comb begin
		if (count_q == '0) begin
			n_act = CMPW'(1);
		end else if (CMPW'(count_q) > CMPW'(MAX_ELEMENTS)) begin
			n_act = CMPW'(MAX_ELEMENTS);
		end else begin
			n_act = CMPW'(count_q);
		end
	end

	// load slot and end-of-vector test
	always_comb begin
		if (done_q) begin
			load_idx = '0;
		end else if (li_q >= NW'(MAX_ELEMENTS)) begin
			load_idx = NW'(MAX_ELEMENTS - 1);
		end else begin
			load_idx = li_q;
		end
		li_next   = load_idx + 1'b1;
		start_enc = (CMPW'(li_next) >= n_act);
	end

	assign out_free = !out_valid || out_ready;
	assign at_last  = (i_q == n_q - 1'b1);
	assign shed_go  = (m_q >= BW'(mrve_pkg::SHED_LIMIT));
	assign root_go  = (m_q > BW'(1));
	assign mul_full = {{EW{1'b0}}, lom_q} * {{SW{1'b0}}, cur_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrve_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == mrve_pkg::CMD_LOAD) begin
						if (start_enc) begin
							state_d = (n_act == CMPW'(1)) ? mrve_pkg::BK_ROOT_RD
							                              : mrve_pkg::BK_RD;
						end
					end else if (out_free) begin
						state_d = mrve_pkg::BK_FETCH;
					end
				end
			end
			mrve_pkg::BK_FETCH:  state_d = mrve_pkg::BK_IDLE;
			mrve_pkg::BK_RD:     state_d = mrve_pkg::BK_GET;
			mrve_pkg::BK_GET:    state_d = mrve_pkg::BK_SHED;
			mrve_pkg::BK_SHED: begin
				if (!shed_go) begin
					if (half_q) begin
						state_d = mrve_pkg::BK_MUL;
					end else if (at_last) begin
						state_d = mrve_pkg::BK_ODD_WR;
					end else begin
						state_d = mrve_pkg::BK_RD;
					end
				end
			end
			mrve_pkg::BK_MUL:    state_d = mrve_pkg::BK_WR;
			mrve_pkg::BK_WR: begin
				state_d = at_last ? mrve_pkg::BK_LAYER : mrve_pkg::BK_RD;
			end
			mrve_pkg::BK_ODD_WR: state_d = mrve_pkg::BK_LAYER;
			mrve_pkg::BK_LAYER: begin
				state_d = (j_q == NW'(1)) ? mrve_pkg::BK_ROOT_RD : mrve_pkg::BK_RD;
			end
			mrve_pkg::BK_ROOT_RD:  state_d = mrve_pkg::BK_ROOT_GET;
			mrve_pkg::BK_ROOT_GET: state_d = mrve_pkg::BK_ROOT_SHED;
			mrve_pkg::BK_ROOT_SHED: begin
				if (!root_go) begin
					state_d = mrve_pkg::BK_IDLE;
				end
			end
			default: state_d = mrve_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer: queue pop, memory writes, byte emission
	always_comb begin
		cmd_pop = 1'b0;
		elem_we = 1'b0;
		elem_wa = j_q[EAW-1:0];
		elem_wd = cur_q;
		emit    = 1'b0;
		case (state_q)
			mrve_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == mrve_pkg::CMD_LOAD) begin
						cmd_pop = 1'b1;
						elem_we = 1'b1;
						elem_wa = load_idx[EAW-1:0];
						elem_wd = EW'(cmd.value);
					end else begin
						cmd_pop = out_free;
					end
				end
			end
			mrve_pkg::BK_SHED:      emit = shed_go;
			mrve_pkg::BK_WR: begin
				elem_we = 1'b1;
				elem_wd = lo_q + prod_q;
			end
			mrve_pkg::BK_ODD_WR:    elem_we = 1'b1;
			mrve_pkg::BK_ROOT_SHED: emit = root_go;
			default: begin
			end
		endcase
		byte_we = emit && (bcnt_q < BCW'(MAX_BYTES));
	end

	// element memory
	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_wa] <= elem_wd;
		end
		elem_rd_q <= elem_mem[i_q[EAW-1:0]];
	end

	// byte memory
	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[bcnt_q[BAW-1:0]] <= cur_q[7:0];
		end
		byte_rd_q <= byte_mem[rd_q[BAW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= mrve_pkg::BOUND_RESET;
			count_q <= mrve_pkg::COUNT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				mrve_pkg::REG_ELEMENT_BOUND: bound_q <= cfg.data;
				mrve_pkg::REG_ELEMENT_COUNT: count_q <= cfg.data[mrve_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mrve_pkg::BK_IDLE;
			li_q      <= '0;
			bcnt_q    <= '0;
			rd_q      <= '0;
			done_q    <= 1'b0;
			n_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			half_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (byte_we) begin
				bcnt_q <= bcnt_q + 1'b1;
			end
			case (state_q)
				mrve_pkg::BK_IDLE: begin
					if (cmd_pop && cmd.kind == mrve_pkg::CMD_LOAD) begin
						li_q <= li_next;
						if (done_q) begin
							done_q <= 1'b0;
							bcnt_q <= '0;
							rd_q   <= '0;
						end
						if (start_enc) begin
							n_q    <= NW'(n_act);
							i_q    <= '0;
							j_q    <= '0;
							half_q <= 1'b0;
						end
					end else if (cmd_pop && done_q && rd_q < bcnt_q) begin
						rd_q <= rd_q + 1'b1;
					end
				end
				mrve_pkg::BK_FETCH:  out_valid <= 1'b1;
				mrve_pkg::BK_SHED: begin
					if (!shed_go && !half_q && !at_last) begin
						half_q <= 1'b1;
						i_q    <= i_q + 1'b1;
					end
				end
				mrve_pkg::BK_WR: begin
					j_q    <= j_q + 1'b1;
					i_q    <= i_q + 1'b1;
					half_q <= 1'b0;
				end
				mrve_pkg::BK_ODD_WR: j_q <= j_q + 1'b1;
				mrve_pkg::BK_LAYER: begin
					n_q    <= j_q;
					i_q    <= '0;
					j_q    <= '0;
					half_q <= 1'b0;
				end
				mrve_pkg::BK_ROOT_SHED: begin
					if (!root_go) begin
						done_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			mrve_pkg::BK_IDLE: begin
				if (cmd_pop && cmd.kind == mrve_pkg::CMD_LOAD) begin
					bc_q <= BW'(bound_q);
					bl_q <= BW'(bound_q);
				end else if (cmd_pop) begin
					// fetch: settle status now, byte arrives next cycle
					flast_q <= 1'b0;
					if (!done_q) begin
						fst_q <= mrve_pkg::ST_NOT_DONE;
					end else if (rd_q >= bcnt_q) begin
						fst_q <= mrve_pkg::ST_NO_BYTES;
					end else begin
						fst_q   <= mrve_pkg::ST_OK;
						flast_q <= (rd_q + 1'b1 == bcnt_q);
					end
				end
			end
			mrve_pkg::BK_FETCH: begin
				out_data.status    <= fst_q;
				out_data.last_byte <= flast_q;
				out_data.out_byte  <= (fst_q == mrve_pkg::ST_OK) ? byte_rd_q : 8'd0;
			end
			mrve_pkg::BK_GET: begin
				cur_q <= elem_rd_q;
				m_q   <= at_last ? bl_q : bc_q;
			end
			mrve_pkg::BK_SHED: begin
				if (shed_go) begin
					cur_q <= cur_q >> 8;
					m_q   <= mrve_pkg::ceil256(m_q);
				end else begin
					if (at_last) begin
						bls_q <= m_q[SW-1:0];
					end else begin
						bcs_q <= m_q[SW-1:0];
					end
					if (!half_q) begin
						lo_q  <= cur_q;
						lom_q <= m_q[SW-1:0];
					end
				end
			end
			mrve_pkg::BK_MUL: prod_q <= mul_full[EW-1:0];
			mrve_pkg::BK_LAYER: begin
				// bounds of the next layer: common one and the last element's
				bc_q <= {{SW{1'b0}}, bcs_q} * {{SW{1'b0}}, bcs_q};
				if (n_q[0]) begin
					bl_q <= {{SW{1'b0}}, bls_q};
				end else begin
					bl_q <= {{SW{1'b0}}, bcs_q} * {{SW{1'b0}}, bls_q};
				end
			end
			mrve_pkg::BK_ROOT_GET: begin
				cur_q <= elem_rd_q;
				m_q   <= bl_q;
			end
			mrve_pkg::BK_ROOT_SHED: begin
				if (root_go) begin
					cur_q <= cur_q >> 8;
					m_q   <= mrve_pkg::ceil256(m_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/mixed_radix_vector_encoder.sv
// ----------------------------------------------------------------------------
// mixed_radix_vector_encoder: shared-bound mixed-radix vector packer
// Top level: input stage, command queue and execution back end.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): a word with action 0 loads the
//   next element; action 1 fetches the next encoded byte. Loads give no
//   result; every fetch gives one out word (out_valid/out_ready/out_data).
//   cfg channel writes element_bound (index 0) or element_count (index 1);
//   cfg_ready is always high, other indexes are ignored. Write only while idle.
//   A word passes the input register and the queue, then the back end takes
//   it: a load in its idle state, a fetch through the idle and fetch states
//   (registered byte memory read) into the out register; no command is taken
//   during the fetch state, and a fetch waits for a free out register. The
//   load that completes the vector starts encoding, run by the back-end
//   sequencer with in_ready low once the queue fills: per layer each element
//   is read and shed byte by byte, each pair is merged, an odd element is
//   copied and the layer closes; then the root is read and shed byte by byte.
//   Reset clears counters and the done flag, loads the register defaults;
//   memories hold no reset. A stalled out word holds in the output register
//   while the front keeps accepting words into the queue until it fills.
module mixed_radix_vector_encoder #(
	parameter int MAX_ELEMENTS  = mrve_pkg::MAX_ELEMENTS_DEF,
	parameter int MAX_BYTES     = mrve_pkg::MAX_BYTES_DEF,
	parameter int ELEMENT_WIDTH = mrve_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  mrve_pkg::in_word_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mrve_pkg::out_word_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mrve_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mrve_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic              push;
	mrve_pkg::cmd_t    push_cmd;
	logic              queue_full;
	logic              pop;
	logic              head_valid;
	mrve_pkg::cmd_t    head_cmd;
	mrve_pkg::cfg_wr_t cfg;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	mrve_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	mrve_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	mrve_back #(
		.MAX_ELEMENTS  (MAX_ELEMENTS),
		.MAX_BYTES     (MAX_BYTES),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (pop),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> rtl/mrve_checker.sv
// ----------------------------------------------------------------------------
// mrve_checker: port-level checks of the encoder
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module mrve_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input mrve_pkg::out_word_t              out_data,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);

	// a stalled out word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("out word changed while stalled");

	// error words carry no byte and no last flag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != mrve_pkg::ST_OK |->
			out_data.out_byte == 8'd0 && !out_data.last_byte)
		else $error("error word carries data");

	// status is one of the three codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status == mrve_pkg::ST_OK ||
			out_data.status == mrve_pkg::ST_NOT_DONE ||
			out_data.status == mrve_pkg::ST_NO_BYTES)
		else $error("bad status code");

	// config writes are never stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind mixed_radix_vector_encoder mrve_checker u_mrve_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mixed_radix_vector_encoder
// Loads vectors under many bound/count settings, fetches the packed bytes and
// checks every out word against a local mixed-radix packing model, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT     = 1000000;
	localparam int N_ELEM    = 1024;
	localparam int N_BYTES   = 4096;
	localparam int SHED_AT   = 16384;

	// packing model and store of expected out words
	class encoder_scoreboard;
		logic [15:0] bound_reg;
		logic [10:0] count_reg;
		logic [31:0] elem [N_ELEM];
		logic [31:0] bnd [N_ELEM];
		logic [7:0]  bytes [N_BYTES];
		int unsigned load_idx, byte_cnt, rd_idx, last_n;
		bit          done, last_load;
		mrve_pkg::out_word_t want [$];
		int          errors, results;

		function new();
			bound_reg = mrve_pkg::BOUND_RESET;
			count_reg = mrve_pkg::COUNT_RESET;
			load_idx = 0; byte_cnt = 0; rd_idx = 0; done = 0;
			last_load = 0; last_n = 1; errors = 0; results = 0;
		endfunction

		function int unsigned active_n();
			int unsigned n;
			n = {21'd0, count_reg};
			if (n < 1) n = 1;
			if (n > N_ELEM) n = N_ELEM;
			return n;
		endfunction

		function void set_reg(logic [mrve_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] d);
			if (idx == mrve_pkg::REG_ELEMENT_BOUND) bound_reg = d;
			else if (idx == mrve_pkg::REG_ELEMENT_COUNT) count_reg = d[10:0];
		endfunction

		function void push_byte(logic [31:0] v);
			if (byte_cnt < N_BYTES) begin
				bytes[byte_cnt] = v[7:0];
				byte_cnt++;
			end
		endfunction

		function logic [31:0] up256(logic [31:0] m);
			return (m >> 8) + {31'd0, |m[7:0]};
		endfunction

		// layered pack of n elements, then root bytes
		function void pack(int unsigned n);
			int unsigned i, j;
			logic [31:0] m, r;
			for (i = 0; i < n; i++) bnd[i] = {16'd0, bound_reg};
			while (n > 1) begin
				for (i = 0; i < n; i++) begin
					m = bnd[i];
					r = elem[i];
					while (m >= SHED_AT) begin
						push_byte(r);
						r = r >> 8;
						m = up256(m);
					end
					bnd[i] = m;
					elem[i] = r;
				end
				j = 0;
				for (i = 0; i + 1 < n; i += 2) begin
					elem[j] = elem[i] + bnd[i] * elem[i+1];
					bnd[j] = bnd[i] * bnd[i+1];
					j++;
				end
				if (n % 2) begin
					elem[j] = elem[n-1];
					bnd[j] = bnd[n-1];
					j++;
				end
				n = j;
			end
			r = elem[0];
			m = bnd[0];
			while (m > 1) begin
				push_byte(r);
				r = r >> 8;
				m = up256(m);
			end
			done = 1;
		endfunction

		function void note(mrve_pkg::in_word_t w);
			mrve_pkg::out_word_t e;
			int unsigned n;
			if (w.action == mrve_pkg::CMD_LOAD) begin
				n = active_n();
				if (done) begin
					done = 0; load_idx = 0; byte_cnt = 0; rd_idx = 0;
				end
				if (load_idx >= N_ELEM) load_idx = N_ELEM - 1;
				elem[load_idx] = {16'd0, w.value};
				load_idx++;
				last_load = 1;
				last_n = n;
				if (load_idx >= n) pack(n);
			end else begin
				last_load = 0;
				e.out_byte = 8'd0;
				e.last_byte = 1'b0;
				if (!done) e.status = mrve_pkg::ST_NOT_DONE;
				else if (rd_idx >= byte_cnt) e.status = mrve_pkg::ST_NO_BYTES;
				else begin
					e.out_byte = bytes[rd_idx];
					e.last_byte = (rd_idx + 1 == byte_cnt);
					e.status = mrve_pkg::ST_OK;
					rd_idx++;
				end
				want.push_back(e);
			end
		endfunction

		function void check(mrve_pkg::out_word_t got);
			mrve_pkg::out_word_t e;
			results++;
			if (want.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected out word %h", got);
				return;
			end
			e = want.pop_front();
			if (got.out_byte !== e.out_byte || got.last_byte !== e.last_byte ||
			    got.status !== e.status) begin
				errors++;
				if (errors <= 10)
					$display("word %0d: expected byte %h last %b status %0d, %s %h last %b status %0d",
						results, e.out_byte, e.last_byte, e.status, "got byte",
						got.out_byte, got.last_byte, got.status);
			end
		endfunction

		// cycles to let pass before a register write
		function int unsigned settle();
			return last_load ? 100 + 12 * last_n : 20;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	mrve_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mrve_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mrve_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [mrve_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	encoder_scoreboard sb = new();
	int tx_idle = 27;
	int rx_idle = 67;
	int cycles = 0;
	int items = 0;
	int vectors = 0;

	mixed_radix_vector_encoder DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watch all three channels at the rising edge
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("mixed_radix_vector_encoder: mismatch");
			$finish;
		end
		if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
		if (in_valid && in_ready) sb.note(in_data);
		if (out_valid && out_ready) sb.check(out_data);
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(0, 99) >= rx_idle);
	end

	task automatic send(logic act, logic [15:0] val);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.action = act;
		in_data.value = val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items++;
	endtask

	// wait for every expected word, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.want.size() != 0) @(posedge clk);
		repeat (sb.settle()) @(posedge clk);
	endtask

	task automatic write_reg(logic [mrve_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic setup(logic [15:0] b, logic [15:0] c);
		drain();
		write_reg(mrve_pkg::REG_ELEMENT_BOUND, b);
		write_reg(mrve_pkg::REG_ELEMENT_COUNT, c);
	endtask

	function automatic logic [15:0] pick_value();
		if (sb.bound_reg == 0 || $urandom_range(0, 9) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, sb.bound_reg - 1));
	endfunction

	// one vector: loads, optional early fetch, then fetches over the bytes
	task automatic run_vector(int nfetch_extra);
		int unsigned n, k, nf;
		n = sb.active_n();
		vectors++;
		for (k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(0, 19) == 0)
				send(mrve_pkg::CMD_FETCH, 16'($urandom_range(0, 65535)));
			send(mrve_pkg::CMD_LOAD, pick_value());
		end
		nf = sb.byte_cnt + nfetch_extra;
		if ($urandom_range(0, 7) == 0) nf = $urandom_range(0, nf);
		for (k = 0; k < nf; k++) send(mrve_pkg::CMD_FETCH, 16'($urandom_range(0, 65535)));
	endtask

	task automatic random_phase(int quota);
		int stop;
		logic [15:0] b, c;
		stop = items + quota;
		while (items < stop) begin
			case ($urandom_range(0, 9))
				0: b = 16'd65535;
				1: b = 16'd1;
				2: b = 16'($urandom_range(16384, 65535));
				3: b = 16'($urandom_range(0, 255));
				default: b = 16'($urandom_range(1, 65535));
			endcase
			c = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 40))
			                                : 16'($urandom_range(1, 12));
			setup(b, c);
			repeat ($urandom_range(1, 2)) run_vector($urandom_range(0, 2));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: early fetch, trivial bounds, zero count, shedding, count cut
		send(mrve_pkg::CMD_FETCH, 16'hFFFF);
		setup(16'd1, 16'd1);
		send(mrve_pkg::CMD_LOAD, 16'hFFFF);
		send(mrve_pkg::CMD_FETCH, 16'h0000);
		setup(16'd0, 16'd0);
		send(mrve_pkg::CMD_LOAD, 16'h1234);
		send(mrve_pkg::CMD_FETCH, 16'h0);
		setup(16'd65535, 16'd2);
		send(mrve_pkg::CMD_LOAD, 16'h0000);
		send(mrve_pkg::CMD_LOAD, 16'hFFFE);
		repeat (6) send(mrve_pkg::CMD_FETCH, 16'h0);
		setup(16'd300, 16'd5);
		send(mrve_pkg::CMD_LOAD, 16'd299);
		send(mrve_pkg::CMD_LOAD, 16'd0);
		send(mrve_pkg::CMD_LOAD, 16'd150);
		send(mrve_pkg::CMD_FETCH, 16'h0);
		drain();
		write_reg(mrve_pkg::REG_ELEMENT_COUNT, 16'd2);
		send(mrve_pkg::CMD_LOAD, 16'd7);
		repeat (4) send(mrve_pkg::CMD_FETCH, 16'h0);

		random_phase(130);
		tx_idle = 67;
		rx_idle = 27;
		random_phase(130);
		tx_idle = 0;
		rx_idle = 0;
		random_phase(110);

		// a load after the bytes are read starts the next vector
		setup(16'd65535, 16'd3);
		run_vector(1);
		send(mrve_pkg::CMD_LOAD, 16'd5);

		drain();
		repeat (200) @(posedge clk);
		sb.errors += sb.want.size();
		$display("covered %0d accepted input words, %0d checked out words, %0d vectors",
			items, sb.results, vectors);
		if (sb.errors == 0) begin
			$display("mixed_radix_vector_encoder: match");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("mixed_radix_vector_encoder: mismatch");
		end
		$finish;
	end
endmodule
